// File: rtl/gbdc_pkg.sv
`timescale 1ns / 1ps
package gbdc_pkg;

  localparam int VERT_W   = 7;
  localparam int PARENT_W = 8;
  localparam int LEVEL_W  = 7;
  localparam int LABEL_W  = 7;
  localparam int INFO_W   = VERT_W + LEVEL_W + LABEL_W;
  localparam int IN_W     = 24;
  localparam int OUT_W    = 32;

  localparam logic [PARENT_W-1:0] PARENT_NONE = 8'hFF;
  localparam logic [LEVEL_W-1:0]  LEVEL_NONE  = 7'h7F;
  localparam logic [VERT_W-1:0]   MIN_VERTS   = 7'd2;

  typedef enum logic [2:0] {
    OP_CLEAR = 3'd0,
    OP_ADD   = 3'd1,
    OP_BFS   = 3'd2,
    OP_DFS   = 3'd3,
    OP_COMP  = 3'd4
  } op_e;

  typedef enum logic [3:0] {
    ST_CLR,
    ST_IDLE,
    ST_AE_RDA,
    ST_AE_WRA,
    ST_AE_RDB,
    ST_AE_WRB,
    ST_START,
    ST_SEED,
    ST_POP,
    ST_LINE,
    ST_ROW,
    ST_SCAN,
    ST_OUT_RD,
    ST_OUT_LD
  } state_e;

endpackage

// File: rtl/gbdc_ram.sv
`timescale 1ns / 1ps
module gbdc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// File: rtl/graph_bfs_dfs_components.sv
// Graph walker over an undirected adjacency bit matrix held in on-chip memory.
// Input transfers on the s_axis group carry op, vertex_a and vertex_b. Op 0
// clears the matrix, op 1 adds an edge, op 2 runs a breadth-first walk, op 3 a
// depth-first walk and op 4 labels connected components. A search produces
// one output transfer per vertex 1..n in ascending order, with tlast on the
// last one; clear and add edge produce nothing. The vertex count n is set by
// the configuration write port; the user must write it only while the block
// is idle, as the block itself does not enforce this. Add edge reads and
// writes row a, then reads and writes row b. A clear writes every row once,
// and after reset the same clearing pass runs before the first input
// transfer is taken. A search pops each vertex off the work list, reads its
// matrix row and level, then scans the row for unseen neighbors, one tree
// edge per cycle; components mode takes a new seed whenever the list empties.
// Each reported vertex passes through a read state and a load state.
// The output register holds a result until it is taken; while the receiver
// stalls, reporting pauses and no new input transfer is taken until the
// search has handed its last result to that register.
`timescale 1ns / 1ps
module graph_bfs_dfs_components #(
  parameter int MAX_VERTICES = 64
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [gbdc_pkg::VERT_W-1:0] cfg_wdata_i,
  input  logic                      s_axis_tvalid,
  output logic                      s_axis_tready,
  // op [2:0], vertex_a [9:3], vertex_b [16:10], zero [23:17]
  input  logic [gbdc_pkg::IN_W-1:0]  s_axis_tdata,
  output logic                      m_axis_tvalid,
  input  logic                      m_axis_tready,
  // vertex [6:0], parent [14:7], level [21:15], component [28:22], zero [31:29]
  output logic [gbdc_pkg::OUT_W-1:0] m_axis_tdata,
  output logic                      m_axis_tlast
);
  import gbdc_pkg::*;

  localparam int VW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
  localparam logic [VERT_W-1:0] MaxN = VERT_W'(MAX_VERTICES);

  state_e state_q, state_d;

  logic [VERT_W-1:0] nv_q, n_w;
  logic [VERT_W-1:0] a_q, b_q;
  logic [VW-1:0] a_idx, b_idx, clr_q, line_q, j_q, col_w, seed_w;
  logic [VW:0] head_q, tail_q, tail_m1;
  logic [MAX_VERTICES-1:0] seen_q, cand_q, nmask, unseen;
  logic [LEVEL_W-1:0] lvl_q;
  logic [LABEL_W-1:0] comp_q;
  logic dfs_q, cmode_q;

  logic [2:0] in_op;
  logic [VERT_W-1:0] in_a, in_b;
  logic edge_ok, start_ok, last_w, out_busy;

  logic adj_we, info_we, wl_we;
  logic [VW-1:0] adj_wa, adj_ra, info_wa, info_ra, wl_wa, wl_ra;
  logic [MAX_VERTICES-1:0] adj_wd, adj_rd;
  logic [INFO_W-1:0] info_wd, info_rd;
  logic [VW-1:0] wl_wd, wl_rd;

  logic out_valid_q;
  logic [OUT_W-1:0] out_data_q;
  logic out_last_q;

  function automatic logic [VW-1:0] lowest(input logic [MAX_VERTICES-1:0] v);
    logic [VW-1:0] r;
    r = '0;
    for (int i = MAX_VERTICES - 1; i >= 0; i--) begin
      if (v[i]) r = VW'(i);
    end
    return r;
  endfunction

  assign n_w = (nv_q < MIN_VERTS) ? MIN_VERTS : ((nv_q > MaxN) ? MaxN : nv_q);

  assign in_op = s_axis_tdata[2:0];
  assign in_a  = s_axis_tdata[9:3];
  assign in_b  = s_axis_tdata[16:10];
  assign edge_ok = (in_a != '0) && (in_a <= n_w) && (in_b != '0) && (in_b <= n_w)
                   && (in_a != in_b);
  assign start_ok = (in_a != '0) && (in_a <= n_w);

  assign a_idx = VW'(a_q - 7'd1);
  assign b_idx = VW'(b_q - 7'd1);
  assign tail_m1 = tail_q - 1'b1;

  always_comb begin
    for (int i = 0; i < MAX_VERTICES; i++) begin
      nmask[i] = (VERT_W'(i) < n_w);
    end
  end

  assign unseen = ~seen_q & nmask;
  assign col_w  = lowest(cand_q);
  assign seed_w = lowest(unseen);
  assign last_w = ((VERT_W'(j_q) + 7'd1) == n_w);
  assign out_busy = out_valid_q && !m_axis_tready;

  assign s_axis_tready = (state_q == ST_IDLE);

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_CLR:    if (clr_q == VW'(MAX_VERTICES - 1)) state_d = ST_IDLE;
      ST_IDLE: begin
        if (s_axis_tvalid) begin
          case (in_op)
            OP_CLEAR: state_d = ST_CLR;
            OP_ADD:   state_d = edge_ok ? ST_AE_RDA : ST_IDLE;
            OP_BFS, OP_DFS: state_d = start_ok ? ST_START : ST_IDLE;
            OP_COMP:  state_d = ST_SEED;
            default:  state_d = ST_IDLE;
          endcase
        end
      end
      ST_AE_RDA: state_d = ST_AE_WRA;
      ST_AE_WRA: state_d = ST_AE_RDB;
      ST_AE_RDB: state_d = ST_AE_WRB;
      ST_AE_WRB: state_d = ST_IDLE;
      ST_START:  state_d = ST_POP;
      ST_SEED:   state_d = (unseen == '0) ? ST_OUT_RD : ST_POP;
      ST_POP: begin
        if (head_q == tail_q) state_d = cmode_q ? ST_SEED : ST_OUT_RD;
        else state_d = ST_LINE;
      end
      ST_LINE:   state_d = ST_ROW;
      ST_ROW:    state_d = ST_SCAN;
      ST_SCAN:   if (cand_q == '0) state_d = ST_POP;
      ST_OUT_RD: state_d = ST_OUT_LD;
      ST_OUT_LD: if (!out_busy) state_d = last_w ? ST_IDLE : ST_OUT_RD;
      default:   state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    adj_we  = 1'b0;
    adj_wa  = a_idx;
    adj_wd  = '0;
    adj_ra  = a_idx;
    info_we = 1'b0;
    info_wa = col_w;
    info_wd = '0;
    info_ra = j_q;
    wl_we   = 1'b0;
    wl_wa   = '0;
    wl_wd   = a_idx;
    wl_ra   = dfs_q ? tail_m1[VW-1:0] : head_q[VW-1:0];
    case (state_q)
      ST_CLR: begin
        adj_we = 1'b1;
        adj_wa = clr_q;
      end
      ST_AE_RDA: adj_ra = a_idx;
      ST_AE_WRA: begin
        adj_we = 1'b1;
        adj_wa = a_idx;
        adj_wd = adj_rd | (MAX_VERTICES'(1) << b_idx);
      end
      ST_AE_RDB: adj_ra = b_idx;
      ST_AE_WRB: begin
        adj_we = 1'b1;
        adj_wa = b_idx;
        adj_wd = adj_rd | (MAX_VERTICES'(1) << a_idx);
      end
      ST_START: begin
        info_we = 1'b1;
        info_wa = a_idx;
        wl_we   = 1'b1;
      end
      ST_SEED: begin
        info_we = (unseen != '0);
        info_wa = seed_w;
        info_wd = {LABEL_W'(comp_q + 7'd1), {LEVEL_W{1'b0}}, {VERT_W{1'b0}}};
        wl_we   = (unseen != '0);
        wl_wd   = seed_w;
      end
      ST_LINE: begin
        adj_ra  = wl_rd;
        info_ra = wl_rd;
      end
      ST_SCAN: begin
        info_we = (cand_q != '0);
        info_wa = col_w;
        info_wd = {comp_q, LEVEL_W'(lvl_q + 7'd1), VERT_W'(VERT_W'(line_q) + 7'd1)};
        wl_we   = (cand_q != '0);
        wl_wa   = tail_q[VW-1:0];
        wl_wd   = col_w;
      end
      default: ;
    endcase
  end

  gbdc_ram #(.WIDTH(MAX_VERTICES), .DEPTH(MAX_VERTICES)) u_adj_ram (
    .clk_i, .we_i(adj_we), .waddr_i(adj_wa), .wdata_i(adj_wd),
    .raddr_i(adj_ra), .rdata_o(adj_rd)
  );

  gbdc_ram #(.WIDTH(INFO_W), .DEPTH(MAX_VERTICES)) u_info_ram (
    .clk_i, .we_i(info_we), .waddr_i(info_wa), .wdata_i(info_wd),
    .raddr_i(info_ra), .rdata_o(info_rd)
  );

  gbdc_ram #(.WIDTH(VW), .DEPTH(MAX_VERTICES)) u_wl_ram (
    .clk_i, .we_i(wl_we), .waddr_i(wl_wa), .wdata_i(wl_wd),
    .raddr_i(wl_ra), .rdata_o(wl_rd)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLR;
      nv_q        <= 7'd64;
      clr_q       <= '0;
      head_q      <= '0;
      tail_q      <= '0;
      comp_q      <= '0;
      seen_q      <= '0;
      cand_q      <= '0;
      dfs_q       <= 1'b0;
      cmode_q     <= 1'b0;
      j_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) nv_q <= cfg_wdata_i;
      if (state_q == ST_OUT_LD && !out_busy) out_valid_q <= 1'b1;
      else if (out_valid_q && m_axis_tready) out_valid_q <= 1'b0;
      case (state_q)
        ST_CLR: clr_q <= clr_q + 1'b1;
        ST_IDLE: begin
          if (s_axis_tvalid) begin
            dfs_q   <= (in_op == OP_DFS);
            cmode_q <= (in_op == OP_COMP);
            clr_q   <= '0;
            comp_q  <= '0;
            seen_q  <= '0;
            j_q     <= '0;
          end
        end
        ST_START: begin
          seen_q <= MAX_VERTICES'(1) << a_idx;
          head_q <= '0;
          tail_q <= (VW+1)'(1);
        end
        ST_SEED: begin
          if (unseen != '0) begin
            seen_q <= seen_q | (MAX_VERTICES'(1) << seed_w);
            comp_q <= comp_q + 7'd1;
            head_q <= '0;
            tail_q <= (VW+1)'(1);
          end
        end
        ST_POP: begin
          if (head_q != tail_q) begin
            if (dfs_q) tail_q <= tail_m1;
            else head_q <= head_q + 1'b1;
          end
        end
        ST_ROW: cand_q <= adj_rd & ~seen_q & nmask & ~(MAX_VERTICES'(1) << line_q);
        ST_SCAN: begin
          if (cand_q != '0) begin
            seen_q <= seen_q | (MAX_VERTICES'(1) << col_w);
            cand_q <= cand_q & ~(MAX_VERTICES'(1) << col_w);
            tail_q <= tail_q + 1'b1;
          end
        end
        ST_OUT_LD: begin
          if (!out_busy) begin
            j_q <= j_q + 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE && s_axis_tvalid) begin
      a_q  <= in_a;
      b_q  <= in_b;
    end
    if (state_q == ST_LINE) line_q <= wl_rd;
    if (state_q == ST_ROW) lvl_q <= info_rd[VERT_W +: LEVEL_W];
    if (state_q == ST_OUT_LD && !out_busy) begin
      out_last_q <= last_w;
      if (cmode_q) begin
        out_data_q <= {3'b000, info_rd[VERT_W+LEVEL_W +: LABEL_W], {LEVEL_W{1'b0}},
                       {PARENT_W{1'b0}}, VERT_W'(VERT_W'(j_q) + 7'd1)};
      end else if (seen_q[j_q]) begin
        out_data_q <= {3'b000, {LABEL_W{1'b0}}, info_rd[VERT_W +: LEVEL_W],
                       {1'b0, info_rd[VERT_W-1:0]}, VERT_W'(VERT_W'(j_q) + 7'd1)};
      end else begin
        out_data_q <= {3'b000, {LABEL_W{1'b0}}, LEVEL_NONE, PARENT_NONE,
                       VERT_W'(VERT_W'(j_q) + 7'd1)};
      end
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tlast  = out_last_q;

`ifndef NO_ASSERTIONS
  ap_tail_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tail_q <= (VW+1)'(MAX_VERTICES))
    else $error("work list overflow");

  ap_head_tail: assert property (@(posedge clk_i) disable iff (!rst_ni)
    head_q <= tail_q)
    else $error("queue head passed tail");

  ap_scan_fresh: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN && cand_q != '0) |-> !seen_q[col_w])
    else $error("vertex visited twice");

  ap_last_vertex: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tlast) |-> (m_axis_tdata[6:0] == n_w))
    else $error("tlast on wrong vertex");
`endif

endmodule

// File: bench/graph_bfs_dfs_components_tb.sv
`timescale 1ns / 1ps
module graph_bfs_dfs_components_tb;
  import gbdc_pkg::*;

  class graph_scoreboard;
    typedef struct packed {
      logic [VERT_W-1:0]   vertex;
      logic [PARENT_W-1:0] parent;
      logic [LEVEL_W-1:0]  level;
      logic [LABEL_W-1:0]  comp;
      logic                last;
    } vertex_report_t;

    bit [63:0]      adj_rows[64];
    int             vert_count;
    int             parent_of[64];
    int             level_of[64];
    int             label_of[64];
    vertex_report_t pending_reports[$];
    int             errors;
    int             matched;
    int             searches;

    function new();
      foreach (adj_rows[i]) adj_rows[i] = '0;
      vert_count = 64;
      errors = 0;
      matched = 0;
      searches = 0;
    endfunction

    function void set_vertices(int value);
      vert_count = value < 2 ? 2 : (value > 64 ? 64 : value);
    endfunction

    function bit [63:0] traverse(int root, bit use_stack, int label);
      bit [63:0] seen;
      int        work[$];
      int        line;
      seen = '0;
      seen[root] = 1'b1;
      parent_of[root] = 0;
      level_of[root] = 0;
      label_of[root] = label;
      work.push_back(root);
      while (work.size() > 0) begin
        line = use_stack ? work.pop_back() : work.pop_front();
        for (int col = 0; col < vert_count; col++) begin
          if (col == line || !adj_rows[line][col] || seen[col]) continue;
          seen[col] = 1'b1;
          parent_of[col] = line + 1;
          level_of[col] = level_of[line] + 1;
          label_of[col] = label;
          work.push_back(col);
        end
      end
      return seen;
    endfunction

    function void note_item(logic [2:0] op, logic [6:0] va, logic [6:0] vb);
      bit [63:0]      seen;
      int             label;
      vertex_report_t rep;
      if (op == OP_CLEAR) begin
        foreach (adj_rows[i]) adj_rows[i] = '0;
      end else if (op == OP_ADD) begin
        if (va >= 1 && va <= vert_count && vb >= 1 && vb <= vert_count && va != vb) begin
          adj_rows[va-1][vb-1] = 1'b1;
          adj_rows[vb-1][va-1] = 1'b1;
        end
      end else if (op == OP_BFS || op == OP_DFS) begin
        if (va >= 1 && va <= vert_count) begin
          searches++;
          seen = traverse(va - 1, op == OP_DFS, 0);
          for (int j = 0; j < vert_count; j++) begin
            rep.vertex = VERT_W'(j + 1);
            rep.parent = seen[j] ? PARENT_W'(parent_of[j]) : PARENT_NONE;
            rep.level  = seen[j] ? LEVEL_W'(level_of[j]) : LEVEL_NONE;
            rep.comp   = '0;
            rep.last   = (j == vert_count - 1);
            pending_reports.push_back(rep);
          end
        end
      end else if (op == OP_COMP) begin
        searches++;
        seen = '0;
        label = 0;
        for (int j = 0; j < vert_count; j++) begin
          if (seen[j]) continue;
          label++;
          seen |= traverse(j, 1'b0, label);
        end
        for (int j = 0; j < vert_count; j++) begin
          rep.vertex = VERT_W'(j + 1);
          rep.parent = '0;
          rep.level  = '0;
          rep.comp   = LABEL_W'(label_of[j]);
          rep.last   = (j == vert_count - 1);
          pending_reports.push_back(rep);
        end
      end
    endfunction

    function void check_result(logic [OUT_W-1:0] data, logic last);
      vertex_report_t got;
      vertex_report_t want;
      got.vertex = data[6:0];
      got.parent = data[14:7];
      got.level  = data[21:15];
      got.comp   = data[28:22];
      got.last   = last;
      if (pending_reports.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none, actual %h", $time, got);
        return;
      end
      want = pending_reports.pop_front();
      if (got !== want || data[31:29] !== 3'b0) begin
        errors++;
        $display("%0t: mismatch, expected v=%0d p=%0d l=%0d c=%0d last=%0b", $time,
                 want.vertex, $signed(want.parent), $signed(want.level), want.comp,
                 want.last);
        $display("%0t:           actual v=%0d p=%0d l=%0d c=%0d last=%0b pad=%0h",
                 $time, got.vertex, $signed(got.parent), $signed(got.level), got.comp,
                 got.last, data[31:29]);
      end else begin
        matched++;
      end
    endfunction
  endclass

  logic                 clk_i;
  logic                 rst_ni;
  logic                 cfg_we_i;
  logic [VERT_W-1:0]    cfg_wdata_i;
  logic                 s_axis_tvalid;
  logic                 s_axis_tready;
  logic [IN_W-1:0]      s_axis_tdata;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready;
  logic [OUT_W-1:0]     m_axis_tdata;
  logic                 m_axis_tlast;

  graph_scoreboard sb;
  int              send_idle_pct;
  int              recv_idle_pct;
  int              hold_cycles;
  int              quiet_cycles;
  int              items_sent;
  int              cfg_writes;

  graph_bfs_dfs_components u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata, m_axis_tlast);
    if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= 20000) begin
      $display("Timeout after %0d cycles without a transfer", quiet_cycles);
      $display("FAIL");
      $finish;
    end
  end

  task automatic send_item(logic [2:0] op, logic [6:0] va, logic [6:0] vb);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {7'b0, vb, va, op};
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_item(op, va, vb);
    items_sent++;
  endtask

  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    while (sb.pending_reports.size() != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
  endtask

  task automatic write_vertices(logic [6:0] value);
    wait_idle();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    sb.set_vertices(value);
    cfg_writes++;
  endtask

  task automatic random_items(int count);
    int          pick;
    int          n;
    logic [2:0]  op;
    logic [6:0]  va;
    logic [6:0]  vb;
    n = sb.vert_count;
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(99);
      va = 7'($urandom_range(n, 1));
      vb = 7'($urandom_range(n, 1));
      if (pick < 55) begin
        op = OP_ADD;
      end else if (pick < 65) begin
        op = OP_BFS;
      end else if (pick < 73) begin
        op = OP_DFS;
      end else if (pick < 79) begin
        op = OP_COMP;
      end else if (pick < 82) begin
        op = OP_CLEAR;
      end else begin
        op = 3'($urandom_range(7));
        va = 7'($urandom);
        vb = 7'($urandom);
      end
      send_item(op, va, vb);
    end
  endtask

  initial begin
    sb = new();
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_wdata_i   = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    m_axis_tready = 1'b0;
    hold_cycles   = 0;
    quiet_cycles  = 0;
    items_sent    = 0;
    cfg_writes    = 0;
    send_idle_pct = 34;
    recv_idle_pct = 48;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_item(OP_BFS, 7'd1, 7'd1);
    send_item(OP_ADD, 7'd1, 7'd64);
    send_item(OP_ADD, 7'd64, 7'd2);
    send_item(OP_ADD, 7'd2, 7'd3);
    send_item(OP_ADD, 7'd3, 7'd1);
    send_item(OP_ADD, 7'd5, 7'd5);
    send_item(OP_ADD, 7'd0, 7'd3);
    send_item(OP_ADD, 7'd65, 7'd3);
    send_item(OP_ADD, 7'd127, 7'd127);
    send_item(OP_ADD, 7'd10, 7'd11);
    send_item(OP_BFS, 7'd1, 7'd0);
    send_item(OP_DFS, 7'd64, 7'd0);
    send_item(OP_COMP, 7'd0, 7'd0);
    send_item(OP_BFS, 7'd0, 7'd0);
    send_item(OP_DFS, 7'd65, 7'd127);
    send_item(3'd5, 7'd1, 7'd2);
    send_item(3'd6, 7'd127, 7'd127);
    send_item(3'd7, 7'd42, 7'd85);
    send_item(OP_CLEAR, 7'd0, 7'd0);
    send_item(OP_COMP, 7'd1, 7'd1);
    send_item(OP_DFS, 7'd64, 7'd1);

    write_vertices(7'd5);
    random_items(18);
    write_vertices(7'd127);
    random_items(18);

    send_idle_pct = 48;
    recv_idle_pct = 34;
    write_vertices(7'd1);
    random_items(16);
    write_vertices(7'd64);
    random_items(16);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_vertices(7'd2);
    random_items(14);
    write_vertices(7'($urandom_range(64, 3)));
    hold_cycles = 1500;
    send_item(OP_COMP, 7'd0, 7'd0);
    random_items(18);

    wait_idle();
    $display("Sent %0d items over %0d vertex-count settings; %0d searches, %0d results matched.",
             items_sent, cfg_writes, sb.searches, sb.matched);
    if (sb.errors == 0) begin
      $display("PASS");
    end else begin
      $display("%0d mismatches seen", sb.errors);
      $display("FAIL");
    end
    $finish;
  end

endmodule
